// File: design/kdt_pkg.sv
// Shared types and constants for the k-mer duplicate table.
`timescale 1ns / 1ps

package kdt_pkg;

   // Field widths fixed by the item and result formats
   localparam int unsigned KEY_IN_W  = 16;
   localparam int unsigned KMER_W    = 64;
   localparam int unsigned GC_W      = 8;
   localparam int unsigned COUNT_W   = 32;
   localparam int unsigned BIN_W     = 6;
   localparam int unsigned SLOTCNT_W = 17;
   localparam int unsigned GCSUM_W   = 24;
   localparam int unsigned TOTAL_W   = 48;

   // Operation codes
   localparam logic OP_RECORD = 1'b0;
   localparam logic OP_REPORT = 1'b1;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // One queued item, as handed from the front to the table engine
   typedef struct packed {
      logic                is_report;
      logic [KEY_IN_W-1:0] prefix_key;
      logic [KMER_W-1:0]   kmer_code;
      logic [GC_W-1:0]     gc_level;
   } kdt_item_type;

   // One table slot
   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [KMER_W-1:0]  kmer;
      logic [GC_W-1:0]    gc;
   } kdt_slot_type;

   // Table walk stream from the engine to the histogram unit
   typedef struct packed {
      logic               start;
      logic               slot_valid;
      logic               slot_last;
      logic [COUNT_W-1:0] count;
      logic [GC_W-1:0]    gc;
   } kdt_walk_type;

endpackage

// File: design/kdt_front.sv
// Front end: accepts items, decodes the operation and queues them for the engine.
`timescale 1ns / 1ps

module kdt_front
   import kdt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_operation,
   input  logic [KEY_IN_W-1:0] req_prefix_key,
   input  logic [KMER_W-1:0]   req_kmer_code,
   input  logic [GC_W-1:0]     req_gc_level,
   input  logic                accept_en,
   output logic                item_valid,
   input  logic                item_ready,
   output kdt_item_type        item
);

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   kdt_item_type        queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   kdt_item_type        new_item;
   logic                push;
   logic                pop;

   // Decode the incoming item
   always_comb begin
      new_item.is_report  = (req_operation == OP_REPORT);
      new_item.prefix_key = req_prefix_key;
      new_item.kmer_code  = req_kmer_code;
      new_item.gc_level   = req_gc_level;
   end

   assign req_ready  = accept_en && (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign item_valid = (count_ff != '0);
   assign item       = queue_ff[rd_ptr_ff];
   assign push       = req_valid && req_ready;
   assign pop        = item_valid && item_ready;

   // Queue pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// File: design/kdt_engine.sv
// Table engine: slot memory, clearing pass, record update and report walk.
`timescale 1ns / 1ps

module kdt_engine
   import kdt_pkg::*;
#(
   parameter int unsigned KEY_BASES = 8
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         item_valid,
   output logic         item_ready,
   input  kdt_item_type item,
   input  logic         hist_busy,
   output logic         clearing,
   output kdt_walk_type walk
);

   localparam int unsigned ADDR_W = 2 * KEY_BASES;
   localparam int unsigned SLOTS  = 1 << ADDR_W;
   localparam logic [ADDR_W-1:0] LAST_ADDR = '1;

   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_UPDATE = 4'b0100,
      ST_WALK   = 4'b1000
   } eng_state_type;

   eng_state_type       state_ff, state_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [ADDR_W-1:0]   key_ff, key_in;
   logic [KMER_W-1:0]   kmer_ff, kmer_in;
   logic [GC_W-1:0]     gc_ff, gc_in;
   logic                walk_valid_ff, walk_valid_in;
   logic                walk_last_ff, walk_last_in;
   kdt_slot_type        rd_word_ff;

   kdt_slot_type        slot_mem [SLOTS];

   logic [ADDR_W+KEY_IN_W-1:0] key_wide;
   logic [ADDR_W-1:0]   item_key;
   logic [ADDR_W-1:0]   rd_addr;
   logic                take;
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   kdt_slot_type        wr_data;

   // Key wraps to the table size
   assign key_wide = {{ADDR_W{1'b0}}, item.prefix_key};
   assign item_key = key_wide[ADDR_W-1:0];

   assign item_ready = (state_ff == ST_IDLE) && (!item.is_report || !hist_busy);
   assign take       = item_valid && item_ready;
   assign clearing   = (state_ff == ST_CLEAR);
   assign rd_addr    = (state_ff == ST_WALK) ? addr_ff : item_key;

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      key_in        = key_ff;
      kmer_in       = kmer_ff;
      gc_in         = gc_ff;
      walk_valid_in = 1'b0;
      walk_last_in  = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            addr_in = addr_ff + ADDR_W'(1);
            if (addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (take) begin
               if (item.is_report) begin
                  state_in = ST_WALK;
                  addr_in  = '0;
               end else begin
                  state_in = ST_UPDATE;
                  key_in   = item_key;
                  kmer_in  = item.kmer_code;
                  gc_in    = item.gc_level;
               end
            end
         end
         ST_UPDATE: begin
            state_in = ST_IDLE;
         end
         ST_WALK: begin
            addr_in       = addr_ff + ADDR_W'(1);
            walk_valid_in = 1'b1;
            walk_last_in  = (addr_ff == LAST_ADDR);
            if (addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            addr_in  = '0;
         end
      endcase
   end

   // Slot write: clearing pass or record update
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = addr_ff;
      wr_data = '0;
      case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
         end
         ST_UPDATE: begin
            wr_addr = key_ff;
            if ((rd_word_ff.count == '0) || (rd_word_ff.kmer > kmer_ff)) begin
               // empty slot or smaller k-mer: take the slot over
               wr_en         = 1'b1;
               wr_data.count = COUNT_W'(1);
               wr_data.kmer  = kmer_ff;
               wr_data.gc    = gc_ff;
            end else if ((rd_word_ff.kmer == kmer_ff) && (rd_word_ff.count != COUNT_MAX)) begin
               // same k-mer: count up, saturating
               wr_en         = 1'b1;
               wr_data       = rd_word_ff;
               wr_data.count = rd_word_ff.count + COUNT_W'(1);
            end
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         addr_ff       <= '0;
         walk_valid_ff <= 1'b0;
         walk_last_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         addr_ff       <= addr_in;
         walk_valid_ff <= walk_valid_in;
         walk_last_ff  <= walk_last_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      kmer_ff <= kmer_in;
      gc_ff   <= gc_in;
   end

   // Slot memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      rd_word_ff <= slot_mem[rd_addr];
   end

   // Walk stream to the histogram unit
   always_comb begin
      walk.start      = take && item.is_report;
      walk.slot_valid = walk_valid_ff;
      walk.slot_last  = walk_last_ff;
      walk.count      = rd_word_ff.count;
      walk.gc         = rd_word_ff.gc;
   end

endmodule

// File: design/kdt_hist.sv
// Histogram unit: per-bin accumulators, run totals and result output.
`timescale 1ns / 1ps

module kdt_hist
   import kdt_pkg::*;
#(
   parameter int unsigned HIST_SIZE = 32
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  kdt_walk_type         walk,
   output logic                 hist_busy,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [BIN_W-1:0]     rsp_bin_index,
   output logic [SLOTCNT_W-1:0] rsp_slot_count,
   output logic [GCSUM_W-1:0]   rsp_gc_total,
   output logic [TOTAL_W-1:0]   rsp_read_total,
   output logic [TOTAL_W-1:0]   rsp_dup_total,
   output logic                 rsp_last_bin
);

   localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(HIST_SIZE - 1);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_ACCUM = 3'b010,
      ST_EMIT  = 3'b100
   } hist_state_type;

   hist_state_type         state_ff, state_in;
   logic [BIN_W-1:0]       bin_ff, bin_in;
   logic [TOTAL_W-1:0]     read_ff, read_in;
   logic [TOTAL_W-1:0]     dup_ff, dup_in;
   logic [SLOTCNT_W-1:0]   slots_ff [HIST_SIZE];
   logic [SLOTCNT_W-1:0]   slots_in [HIST_SIZE];
   logic [GCSUM_W-1:0]     gcsum_ff [HIST_SIZE];
   logic [GCSUM_W-1:0]     gcsum_in [HIST_SIZE];

   logic                   hit;
   logic                   shift;
   logic [BIN_W-1:0]       hit_bin;
   logic [TOTAL_W:0]       read_sum;
   logic [TOTAL_W:0]       dup_sum;

   assign hit   = (state_ff == ST_ACCUM) && walk.slot_valid && (walk.count != '0);
   assign shift = (state_ff == ST_EMIT) && rsp_ready;

   // High counts land in the last bin
   assign hit_bin = (walk.count >= COUNT_W'(HIST_SIZE - 1)) ? LAST_BIN
                                                            : walk.count[BIN_W-1:0];

   assign read_sum = {1'b0, read_ff} + (TOTAL_W + 1)'(walk.count);
   assign dup_sum  = {1'b0, dup_ff} + (TOTAL_W + 1)'(walk.count - COUNT_W'(1));

   // Control and totals
   always_comb begin
      state_in = state_ff;
      bin_in   = bin_ff;
      read_in  = read_ff;
      dup_in   = dup_ff;
      case (state_ff)
         ST_IDLE: begin
            if (walk.start) begin
               state_in = ST_ACCUM;
               bin_in   = '0;
               read_in  = '0;
               dup_in   = '0;
            end
         end
         ST_ACCUM: begin
            if (hit) begin
               read_in = read_sum[TOTAL_W] ? '1 : read_sum[TOTAL_W-1:0];
               dup_in  = dup_sum[TOTAL_W]  ? '1 : dup_sum[TOTAL_W-1:0];
            end
            if (walk.slot_valid && walk.slot_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               bin_in = bin_ff + BIN_W'(1);
               if (bin_ff == LAST_BIN) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Bin lanes: clear on start, update on a hit, shift down while emitting
   always_comb begin
      logic [GCSUM_W:0] gc_sum;
      int unsigned      up;
      for (int unsigned i = 0; i < HIST_SIZE; i++) begin
         up          = (i < HIST_SIZE - 1) ? i + 1 : i;
         gc_sum      = {1'b0, gcsum_ff[i]} + (GCSUM_W + 1)'(walk.gc);
         slots_in[i] = slots_ff[i];
         gcsum_in[i] = gcsum_ff[i];
         if ((state_ff == ST_IDLE) && walk.start) begin
            slots_in[i] = '0;
            gcsum_in[i] = '0;
         end else if (hit && (hit_bin == BIN_W'(i))) begin
            if (slots_ff[i] != '1) begin
               slots_in[i] = slots_ff[i] + SLOTCNT_W'(1);
            end
            gcsum_in[i] = gc_sum[GCSUM_W] ? '1 : gc_sum[GCSUM_W-1:0];
         end else if (shift) begin
            slots_in[i] = slots_ff[up];
            gcsum_in[i] = gcsum_ff[up];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff   <= bin_in;
      read_ff  <= read_in;
      dup_ff   <= dup_in;
      slots_ff <= slots_in;
      gcsum_ff <= gcsum_in;
   end

   // Results come straight from registers
   assign hist_busy      = (state_ff != ST_IDLE);
   assign rsp_valid      = (state_ff == ST_EMIT);
   assign rsp_bin_index  = bin_ff;
   assign rsp_slot_count = slots_ff[0];
   assign rsp_gc_total   = gcsum_ff[0];
   assign rsp_read_total = read_ff;
   assign rsp_dup_total  = dup_ff;
   assign rsp_last_bin   = (bin_ff == LAST_BIN);

endmodule

// File: design/kmer_duplicate_table.sv
// Record items: one slot memory read in the engine, then one write.
// Report items: the engine walks the slot memory one slot per cycle,
// then HIST_SIZE results at up to one per cycle; a two-item queue takes items meanwhile.
// Reset: a clearing pass zeroes every slot, req_ready low throughout.
// Histogram bins and totals are cleared at the start of each report.
`timescale 1ns / 1ps

module kmer_duplicate_table
   import kdt_pkg::*;
#(
   parameter int unsigned KEY_BASES = 8,
   parameter int unsigned HIST_SIZE = 32
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_operation,
   input  logic [KEY_IN_W-1:0]  req_prefix_key,
   input  logic [KMER_W-1:0]    req_kmer_code,
   input  logic [GC_W-1:0]      req_gc_level,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [BIN_W-1:0]     rsp_bin_index,
   output logic [SLOTCNT_W-1:0] rsp_slot_count,
   output logic [GCSUM_W-1:0]   rsp_gc_total,
   output logic [TOTAL_W-1:0]   rsp_read_total,
   output logic [TOTAL_W-1:0]   rsp_dup_total,
   output logic                 rsp_last_bin
);

   logic         item_valid;
   logic         item_ready;
   kdt_item_type item;
   logic         clearing;
   logic         hist_busy;
   kdt_walk_type walk;

   kdt_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .req_prefix_key (req_prefix_key),
      .req_kmer_code  (req_kmer_code),
      .req_gc_level   (req_gc_level),
      .accept_en      (!clearing),
      .item_valid     (item_valid),
      .item_ready     (item_ready),
      .item           (item)
   );

   kdt_engine #(
      .KEY_BASES (KEY_BASES)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item),
      .hist_busy  (hist_busy),
      .clearing   (clearing),
      .walk       (walk)
   );

   kdt_hist #(
      .HIST_SIZE (HIST_SIZE)
   ) u_hist (
      .clock          (clock),
      .reset          (reset),
      .walk           (walk),
      .hist_busy      (hist_busy),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_bin_index  (rsp_bin_index),
      .rsp_slot_count (rsp_slot_count),
      .rsp_gc_total   (rsp_gc_total),
      .rsp_read_total (rsp_read_total),
      .rsp_dup_total  (rsp_dup_total),
      .rsp_last_bin   (rsp_last_bin)
   );

endmodule

// File: test/tb_top.sv
// Self-checking testbench for the k-mer duplicate table: directed probes, then random traffic.
`timescale 1ns / 1ps

module tb_top;
   import kdt_pkg::*;

   localparam int unsigned KEY_BASES    = 8;
   localparam int unsigned HIST_SIZE    = 32;
   localparam int unsigned SLOT_COUNT   = 1 << (2 * KEY_BASES);
   localparam int unsigned PROBE_COUNT  = 16;
   localparam int unsigned RANDOM_ITEMS = 450;
   localparam longint unsigned TOTAL_MAX  = 64'h0000_FFFF_FFFF_FFFF;
   localparam int unsigned     GCSUM_MAX  = 32'h00FF_FFFF;
   localparam logic [SLOTCNT_W-1:0] SLOTCNT_MAX = '1;

   // One histogram result as the block should emit it
   typedef struct {
      logic [BIN_W-1:0]     bin_no;
      logic [SLOTCNT_W-1:0] slot_count;
      logic [GCSUM_W-1:0]   gc_total;
      logic [TOTAL_W-1:0]   read_total;
      logic [TOTAL_W-1:0]   dup_total;
      logic                 last_bin;
   } bin_result_type;

   // One directed probe; empty_hist marks a report whose results are typed in
   typedef struct {
      logic                op;
      logic [KEY_IN_W-1:0] key;
      logic [KMER_W-1:0]   kmer;
      logic [GC_W-1:0]     gc;
      bit                  empty_hist;
   } probe_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_operation = OP_RECORD;
   logic [KEY_IN_W-1:0]  req_prefix_key = '0;
   logic [KMER_W-1:0]    req_kmer_code = '0;
   logic [GC_W-1:0]      req_gc_level = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [BIN_W-1:0]     rsp_bin_index;
   logic [SLOTCNT_W-1:0] rsp_slot_count;
   logic [GCSUM_W-1:0]   rsp_gc_total;
   logic [TOTAL_W-1:0]   rsp_read_total;
   logic [TOTAL_W-1:0]   rsp_dup_total;
   logic                 rsp_last_bin;

   // Shadow copy of the slot table
   int unsigned     slot_hits [SLOT_COUNT];
   logic [KMER_W-1:0] slot_least [SLOT_COUNT];
   logic [GC_W-1:0]   slot_gcbyte [SLOT_COUNT];

   bin_result_type hist_expected [$];
   int unsigned mismatch_count = 0;
   int unsigned stall_left = 0;
   bit          calm = 1'b0;

   probe_row_type probe_rows [PROBE_COUNT] = '{
      // empty table straight after the clearing pass
      '{OP_REPORT, 16'h0000, 64'h0000_0000_0000_0000, 8'h00, 1'b1},
      // lowest key, k-mer and GC: fill, then an equal hit keeps the first GC byte
      '{OP_RECORD, 16'h0000, 64'h0000_0000_0000_0000, 8'h00, 1'b0},
      '{OP_RECORD, 16'h0000, 64'h0000_0000_0000_0000, 8'hFF, 1'b0},
      // highest key: fill, smaller replaces, larger ignored
      '{OP_RECORD, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 1'b0},
      '{OP_RECORD, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFE, 8'h01, 1'b0},
      '{OP_RECORD, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'h07, 1'b0},
      // a slot counted up to three, then hit by a larger k-mer
      '{OP_RECORD, 16'h1234, 64'h5555_5555_5555_5555, 8'hAA, 1'b0},
      '{OP_RECORD, 16'h1234, 64'h5555_5555_5555_5555, 8'h55, 1'b0},
      '{OP_RECORD, 16'h1234, 64'h5555_5555_5555_5555, 8'h0F, 1'b0},
      '{OP_RECORD, 16'h1234, 64'hAAAA_AAAA_AAAA_AAAA, 8'hF0, 1'b0},
      // report with its unused fields all ones
      '{OP_REPORT, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 1'b0},
      // k-mers either side of the top bit
      '{OP_RECORD, 16'hA5A5, 64'h8000_0000_0000_0000, 8'h80, 1'b0},
      '{OP_RECORD, 16'hA5A5, 64'h7FFF_FFFF_FFFF_FFFF, 8'h7F, 1'b0},
      '{OP_RECORD, 16'hA5A5, 64'h8000_0000_0000_0000, 8'h11, 1'b0},
      '{OP_RECORD, 16'h5A5A, 64'h0000_0000_0000_0001, 8'h01, 1'b0},
      '{OP_REPORT, 16'h0000, 64'h0000_0000_0000_0000, 8'h00, 1'b0}
   };

   kmer_duplicate_table #(
      .KEY_BASES (KEY_BASES),
      .HIST_SIZE (HIST_SIZE)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .req_prefix_key (req_prefix_key),
      .req_kmer_code  (req_kmer_code),
      .req_gc_level   (req_gc_level),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_bin_index  (rsp_bin_index),
      .rsp_slot_count (rsp_slot_count),
      .rsp_gc_total   (rsp_gc_total),
      .rsp_read_total (rsp_read_total),
      .rsp_dup_total  (rsp_dup_total),
      .rsp_last_bin   (rsp_last_bin)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Idle length: mostly none, some short, a few long
   function automatic int unsigned idle_span();
      int unsigned r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic longint unsigned sat_total(longint unsigned acc, longint unsigned add);
      if (add >= TOTAL_MAX - acc) return TOTAL_MAX;
      return acc + add;
   endfunction

   // Record item: fill, count up, replace on smaller, ignore larger
   function automatic void note_read(logic [KEY_IN_W-1:0] key, logic [KMER_W-1:0] kmer,
                                     logic [GC_W-1:0] gc);
      int unsigned s;
      s = key & (SLOT_COUNT - 1);
      if (slot_hits[s] == 0 || kmer < slot_least[s]) begin
         slot_hits[s]   = 1;
         slot_least[s]  = kmer;
         slot_gcbyte[s] = gc;
      end else if (kmer == slot_least[s]) begin
         if (slot_hits[s] != COUNT_MAX) slot_hits[s]++;
      end
   endfunction

   // Report item: walk the shadow table and queue one result per bin
   function automatic void tally_histogram();
      logic [SLOTCNT_W-1:0] bin_slots [HIST_SIZE];
      int unsigned          bin_gc [HIST_SIZE];
      longint unsigned      reads_sum;
      longint unsigned      dups_sum;
      int unsigned          s;
      int unsigned          b;
      bin_result_type       row;
      reads_sum = 0;
      dups_sum  = 0;
      for (b = 0; b < HIST_SIZE; b++) begin
         bin_slots[b] = '0;
         bin_gc[b]    = 0;
      end
      for (s = 0; s < SLOT_COUNT; s++) begin
         if (slot_hits[s] == 0) continue;
         reads_sum = sat_total(reads_sum, slot_hits[s]);
         dups_sum  = sat_total(dups_sum, slot_hits[s] - 1);
         // counts at or above the last bin collect there
         b = (slot_hits[s] >= HIST_SIZE - 1) ? HIST_SIZE - 1 : slot_hits[s];
         if (bin_slots[b] != SLOTCNT_MAX) bin_slots[b]++;
         bin_gc[b] = bin_gc[b] + slot_gcbyte[s];
         if (bin_gc[b] > GCSUM_MAX) bin_gc[b] = GCSUM_MAX;
      end
      for (b = 0; b < HIST_SIZE; b++) begin
         row.bin_no     = BIN_W'(b);
         row.slot_count = bin_slots[b];
         row.gc_total   = GCSUM_W'(bin_gc[b]);
         row.read_total = TOTAL_W'(reads_sum);
         row.dup_total  = TOTAL_W'(dups_sum);
         row.last_bin   = (b == HIST_SIZE - 1);
         hist_expected.push_back(row);
      end
   endfunction

   // Present one item, hold it until taken, then update the shadow table or queue its results
   task automatic send_item(logic op, logic [KEY_IN_W-1:0] key, logic [KMER_W-1:0] kmer,
                            logic [GC_W-1:0] gc, bit empty_hist);
      int unsigned gap;
      int unsigned b;
      bin_result_type row;
      gap = idle_span();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_prefix_key <= key;
      req_kmer_code  <= kmer;
      req_gc_level   <= gc;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (op == OP_RECORD) begin
         note_read(key, kmer, gc);
      end else if (empty_hist) begin
         // nothing recorded yet: every bin and total is zero
         for (b = 0; b < HIST_SIZE; b++) begin
            row = '{BIN_W'(b), '0, '0, '0, '0, b == HIST_SIZE - 1};
            hist_expected.push_back(row);
         end
      end else begin
         tally_histogram();
      end
   endtask

   // Hold off the sender until every queued result is back
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (hist_expected.size() != 0);
   endtask

   function automatic void check_field(string name, longint unsigned want, logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   // Result side: compare each taken item, then pick next cycle's ready
   always @(posedge clock) begin : rsp_side
      bin_result_type want;
      if (rsp_valid && rsp_ready) begin
         if (hist_expected.size() == 0) begin
            $error("result with no prediction waiting, bin_index %0d", rsp_bin_index);
            mismatch_count++;
         end else begin
            want = hist_expected.pop_front();
            check_field("bin_index", want.bin_no, rsp_bin_index);
            check_field("slot_count", want.slot_count, rsp_slot_count);
            check_field("gc_total", want.gc_total, rsp_gc_total);
            check_field("read_total", want.read_total, rsp_read_total);
            check_field("dup_total", want.dup_total, rsp_dup_total);
            check_field("last_bin", want.last_bin, rsp_last_bin);
         end
      end
      if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= idle_span();
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Stimulus
   initial begin : stimulus
      logic [KEY_IN_W-1:0] hot_keys [4];
      logic [KMER_W-1:0]   hot_kmers [4];
      logic [KEY_IN_W-1:0] window_base;
      logic [KEY_IN_W-1:0] key;
      logic [KMER_W-1:0]   kmer;
      int unsigned         i;
      int unsigned         j;
      int unsigned         mode;
      int unsigned         nudge;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed probes
      for (i = 0; i < PROBE_COUNT; i++) begin
         send_item(probe_rows[i].op, probe_rows[i].key, probe_rows[i].kmer,
                   probe_rows[i].gc, probe_rows[i].empty_hist);
      end
      drain_results();

      for (j = 0; j < 4; j++) begin
         hot_keys[j]  = KEY_IN_W'($urandom);
         hot_kmers[j] = {$urandom, $urandom};
      end
      window_base = KEY_IN_W'($urandom);

      // random traffic, a report every 90 items
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
         if (i == 200) drain_results();
         if (i % 90 == 89) begin
            send_item(OP_REPORT, KEY_IN_W'($urandom), {$urandom, $urandom},
                      GC_W'($urandom), 1'b0);
         end else begin
            mode = $urandom_range(0, 99);
            if (mode < 25) begin
               // one key hammered with its own k-mer: drives the count past the last bin
               key  = hot_keys[0];
               kmer = hot_kmers[0];
            end else if (mode < 55) begin
               // mostly equal hits, sometimes a smaller or larger neighbour
               j     = $urandom_range(1, 3);
               key   = hot_keys[j];
               nudge = $urandom_range(0, 9);
               kmer  = hot_kmers[j];
               if (nudge == 0) kmer = hot_kmers[j] - 1;
               else if (nudge == 1) kmer = hot_kmers[j] + 1;
               if (kmer < hot_kmers[j]) hot_kmers[j] = kmer;
            end else if (mode < 80) begin
               // small key window with tiny k-mers: fills, ties, replacements
               key  = KEY_IN_W'(window_base + $urandom_range(0, 15));
               kmer = KMER_W'($urandom_range(0, 7));
            end else begin
               key  = KEY_IN_W'($urandom);
               kmer = {$urandom, $urandom};
            end
            send_item(OP_RECORD, key, kmer, GC_W'($urandom), 1'b0);
         end
      end

      drain_results();
      repeat (64) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #40_000_000;
      $display("tb_top failed");
      $finish;
   end

endmodule

// File: sim.f
design/kdt_pkg.sv
design/kdt_front.sv
design/kdt_engine.sv
design/kdt_hist.sv
design/kmer_duplicate_table.sv
test/tb_top.sv
